>>> hw/rtl/ocu_pkg.sv
`default_nettype none
package ocu_pkg;

  typedef struct packed {
    logic              key_up;
    logic              key_down;
    logic              key_forward;
    logic              key_back;
    logic              key_left;
    logic              key_right;
    logic              drag;
    logic signed [15:0] cursor_dx;
    logic signed [15:0] cursor_dy;
    logic signed [15:0] scroll_dy;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
  } out_item_t;

  // register indexes
  localparam logic [1:0] CFG_MOVE_SPEED   = 2'd0;
  localparam logic [1:0] CFG_ROTATE_SPEED = 2'd1;
  localparam logic [1:0] CFG_SCROLL_SPEED = 2'd2;

  localparam logic [23:0] MOVE_SPEED_RST   = 24'd3277;
  localparam logic [23:0] ROTATE_SPEED_RST = 24'd683565;
  localparam logic [23:0] SCROLL_SPEED_RST = 24'd6554;

  localparam logic signed [31:0] RADIUS_RST   = 32'sd196608;
  localparam logic signed [41:0] RADIUS_FLOOR = 42'sd655;
  localparam logic signed [41:0] PITCH_LIMIT  = 42'sd1066906171;
  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam int unsigned        CORDIC_STEPS = 30;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cordic_req_t;

  function automatic logic signed [33:0] atan_lut(input logic [4:0] idx);
    logic signed [33:0] v;
    unique case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // round to nearest, halves up, drop 30 fraction bits
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return t[63:30];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) r = 32'sh7fffffff;
    else if (v < -42'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ocu_cordic.sv
`default_nettype none
module ocu_cordic (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ocu_pkg::cordic_req_t req,
  output logic                      done,
  output logic signed [31:0]        sin_q30,
  output logic signed [31:0]        cos_q30
);
  import ocu_pkg::*;

  logic signed [33:0] x_r, y_r, z_r;
  logic [4:0]         cnt_r;
  logic               busy_r, done_r, flip_r;
  logic [31:0]        half_turn_chk, rot_ang;
  logic signed [33:0] xo, yo;

  assign half_turn_chk = req.angle + 32'h40000000;
  assign rot_ang = half_turn_chk[31] ? req.angle + 32'h80000000 : req.angle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        z_r    <= {{2{rot_ang[31]}}, rot_ang};
        flip_r <= half_turn_chk[31];
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - (y_r >>> cnt_r);
          y_r <= y_r + (x_r >>> cnt_r);
          z_r <= z_r - atan_lut(cnt_r);
        end else begin
          x_r <= x_r + (y_r >>> cnt_r);
          y_r <= y_r - (x_r >>> cnt_r);
          z_r <= z_r + atan_lut(cnt_r);
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    xo = flip_r ? -x_r : x_r;
    yo = flip_r ? -y_r : y_r;
    if (xo > ONE_Q30) xo = ONE_Q30;
    else if (xo < -ONE_Q30) xo = -ONE_Q30;
    if (yo > ONE_Q30) yo = ONE_Q30;
    else if (yo < -ONE_Q30) yo = -ONE_Q30;
  end

  assign done    = done_r;
  assign sin_q30 = yo[31:0];
  assign cos_q30 = xo[31:0];
endmodule
`default_nettype wire

>>> hw/rtl/ocu_mul.sv
`default_nettype none
module ocu_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] op_a,
  input  wire logic signed [31:0] op_b,
  output logic signed [63:0]      prod
);
  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;
endmodule
`default_nettype wire

>>> hw/rtl/orbit_camera_update_top.sv
`default_nettype none
// channel  | ports                                   | dir
// input    | in_valid, in_stall, in_data             | item in, stall out
// result   | out_valid, out_stall, out_data          | item out, stall in
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | register write in
//
// each item takes three passes of the shared cordic unit plus 13 steps that
// issue ten products through the single 32x32 multiplier; the result loads in
// the last step, ST_MM, which waits while the held result is not taken
// in_stall is high from acceptance until the item's result is loaded
// the result register frees the input side; a held result only blocks the
// very last step of the next item
// synchronous active-low reset restores registers and camera state
module orbit_camera_update_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ocu_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ocu_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);
  import ocu_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_COR1, ST_MA, ST_MB, ST_MC, ST_MD, ST_ME, ST_MF,
    ST_COR2, ST_COR3, ST_MG, ST_MH, ST_MI, ST_MJ, ST_MK, ST_ML, ST_MM
  } state_t;

  state_t state_r;

  // config registers
  logic [23:0] move_r, rot_r, scroll_r;

  // camera state
  logic [31:0]        heading_r;
  logic signed [31:0] pitch_r, radius_r, cx_r, cy_r, cz_r;

  // working registers
  in_item_t           item_r;
  logic signed [31:0] sa_r, ca_r, sp_r, cp_r, f_r, px_r, py_r;
  logic signed [33:0] st_r;
  out_item_t          out_r;
  logic               out_valid_r;

  // shared units
  cordic_req_t        creq;
  logic               c_done;
  logic signed [31:0] c_sin, c_cos;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;

  logic               in_acc, out_free;
  logic signed [33:0] rp, ctv, vx, vy, vz, ms34;
  logic signed [41:0] pitch_sum, rad_sum;
  logic signed [31:0] ms32;

  ocu_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .req(creq),
    .done(c_done), .sin_q30(c_sin), .cos_q30(c_cos)
  );

  ocu_mul u_mul (
    .clk(clk), .op_a(op_a), .op_b(op_b), .prod(prod)
  );

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ms32 = {8'd0, move_r};
  assign ms34 = {10'd0, move_r};
  assign rp   = rnd30(prod);
  assign ctv  = rp;

  // cordic requests: heading at entry, new heading, then pitch
  always_comb begin
    creq.start = (state_r == ST_IDLE && in_acc) || state_r == ST_MF ||
                 (state_r == ST_COR2 && c_done);
    creq.angle = (state_r == ST_COR2) ? pitch_r : heading_r;
  end

  // multiplier operand select
  always_comb begin
    unique case (state_r)
      ST_MA:   begin op_a = ms32; op_b = sa_r; end
      ST_MB:   begin op_a = ms32; op_b = ca_r; end
      ST_MC:   begin op_a = 32'(item_r.cursor_dx); op_b = {8'd0, rot_r}; end
      ST_MD:   begin op_a = 32'(item_r.cursor_dy); op_b = {8'd0, rot_r}; end
      ST_ME:   begin op_a = 32'(item_r.scroll_dy); op_b = {8'd0, scroll_r}; end
      ST_MG:   begin op_a = sa_r; op_b = cp_r; end
      ST_MH:   begin op_a = sp_r; op_b = radius_r; end
      ST_MI:   begin op_a = f_r;  op_b = radius_r; end
      ST_MJ:   begin op_a = ca_r; op_b = cp_r; end
      // last product stays on the multiplier while the result waits
      ST_ML, ST_MM: begin op_a = f_r; op_b = radius_r; end
      default: begin op_a = '0;   op_b = '0; end
    endcase
  end

  // target velocity from keys, st_r = speed*sin, ctv = speed*cos
  always_comb begin
    vx = '0;
    vy = '0;
    vz = '0;
    if (item_r.key_up)      vy = vy + ms34;
    if (item_r.key_down)    vy = vy - ms34;
    if (item_r.key_forward) begin vz = vz - ctv; vx = vx - st_r; end
    if (item_r.key_back)    begin vz = vz + ctv; vx = vx + st_r; end
    if (item_r.key_left)    begin vx = vx - ctv; vz = vz + st_r; end
    if (item_r.key_right)   begin vx = vx + ctv; vz = vz - st_r; end
  end

  assign pitch_sum = 42'(pitch_r) + 42'(prod);
  assign rad_sum   = 42'(radius_r) - 42'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      move_r      <= MOVE_SPEED_RST;
      rot_r       <= ROTATE_SPEED_RST;
      scroll_r    <= SCROLL_SPEED_RST;
      heading_r   <= '0;
      pitch_r     <= '0;
      radius_r    <= RADIUS_RST;
      cx_r        <= '0;
      cy_r        <= '0;
      cz_r        <= '0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_MM) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MOVE_SPEED:   move_r   <= cfg_data;
          CFG_ROTATE_SPEED: rot_r    <= cfg_data;
          CFG_SCROLL_SPEED: scroll_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: if (in_acc) begin
          item_r  <= in_data;
          state_r <= ST_COR1;
        end
        ST_COR1: if (c_done) begin
          sa_r    <= c_sin;
          ca_r    <= c_cos;
          state_r <= ST_MA;
        end
        ST_MA: state_r <= ST_MB;
        ST_MB: begin
          st_r    <= rp;
          state_r <= ST_MC;
        end
        ST_MC: begin
          // target moves with the heading from before this item
          cx_r    <= sat32(42'(cx_r) + 42'(vx));
          cy_r    <= sat32(42'(cy_r) + 42'(vy));
          cz_r    <= sat32(42'(cz_r) + 42'(vz));
          state_r <= ST_MD;
        end
        ST_MD: begin
          if (item_r.drag) heading_r <= heading_r - prod[31:0];
          state_r <= ST_ME;
        end
        ST_ME: begin
          if (item_r.drag) begin
            if (pitch_sum > PITCH_LIMIT) pitch_r <= PITCH_LIMIT[31:0];
            else if (pitch_sum < -PITCH_LIMIT) pitch_r <= 32'(-PITCH_LIMIT);
            else pitch_r <= pitch_sum[31:0];
          end
          state_r <= ST_MF;
        end
        ST_MF: begin
          // saturate, then floor
          if (42'(sat32(rad_sum)) < RADIUS_FLOOR) radius_r <= RADIUS_FLOOR[31:0];
          else radius_r <= sat32(rad_sum);
          state_r <= ST_COR2;
        end
        ST_COR2: if (c_done) begin
          sa_r    <= c_sin;
          ca_r    <= c_cos;
          state_r <= ST_COR3;
        end
        ST_COR3: if (c_done) begin
          sp_r    <= c_sin;
          cp_r    <= c_cos;
          state_r <= ST_MG;
        end
        ST_MG: state_r <= ST_MH;
        ST_MH: begin
          f_r     <= rp[31:0];
          state_r <= ST_MI;
        end
        ST_MI: begin
          py_r    <= sat32(42'(cy_r) + 42'(rp));
          state_r <= ST_MJ;
        end
        ST_MJ: begin
          px_r    <= sat32(42'(cx_r) + 42'(rp));
          state_r <= ST_MK;
        end
        ST_MK: begin
          f_r     <= rp[31:0];
          state_r <= ST_ML;
        end
        ST_ML: state_r <= ST_MM;
        ST_MM: if (out_free) begin
          out_r.pos_x  <= px_r;
          out_r.pos_y  <= py_r;
          out_r.pos_z  <= sat32(42'(cz_r) + 42'(rp));
          out_r.look_x <= cx_r;
          out_r.look_y <= cy_r;
          out_r.look_z <= cz_r;
          out_valid_r  <= 1'b1;
          state_r      <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // the multiply result in the last step must not be lost while waiting
  a_mm_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MM && !out_free) |=> (state_r == ST_MM))
    else $error("final step left while result register busy");

  a_radius_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (42'(radius_r) >= RADIUS_FLOOR))
    else $error("orbit radius below floor");

  a_pitch_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (42'(pitch_r) <= PITCH_LIMIT) && (42'(pitch_r) >= -PITCH_LIMIT))
    else $error("pitch outside limit");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("block not busy after accepting an item");

endmodule
`default_nettype wire

>>> dv/orbit_camera_update_top_test.sv
`timescale 1ns / 1ps
module orbit_camera_update_top_test;
  import ocu_pkg::*;

  localparam int N_RANDOM    = 350;
  localparam int WATCHDOG    = 20000;
  localparam int PITCH_LIM   = 1066906171;
  localparam longint ONE30   = 64'sd1073741824;
  localparam longint GAIN    = 64'sd652032874;

  // camera model: settings and frame-to-frame state
  class camera_scoreboard;
    bit [23:0]   move_spd, rot_spd, scroll_spd;
    bit [31:0]   heading;
    longint      pitch, radius, cx, cy, cz;
    out_item_t   pending[$];
    int          errors, checked;

    function void init();
      move_spd = MOVE_SPEED_RST;
      rot_spd = ROTATE_SPEED_RST;
      scroll_spd = SCROLL_SPEED_RST;
      heading = '0;
      pitch = 0;
      radius = 196608;
      cx = 0;
      cy = 0;
      cz = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(bit [1:0] idx, bit [23:0] val);
      case (idx)
        CFG_MOVE_SPEED:   move_spd = val;
        CFG_ROTATE_SPEED: rot_spd = val;
        CFG_SCROLL_SPEED: scroll_spd = val;
        default: ;
      endcase
    endfunction

    // arithmetic shift floors, >>> on longint does that
    function longint rnd(longint v);
      return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unit(longint v);
      if (v > ONE30) return ONE30;
      if (v < -ONE30) return -ONE30;
      return v;
    endfunction

    // 30-step rotation, folded into the right half plane first
    function void sincos(bit [31:0] a, output longint s, output longint c);
      bit [31:0] r;
      bit flip;
      longint x, y, z, dx, dy;
      bit [31:0] q;
      r = a;
      flip = 0;
      x = GAIN;
      y = 0;
      q = a + 32'h4000_0000;
      if (q >= 32'h8000_0000) begin
        r = a + 32'h8000_0000;
        flip = 1;
      end
      z = longint'($signed(r));
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_lut(i[4:0]));
        end else begin
          x += dx; y -= dy; z += longint'(atan_lut(i[4:0]));
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      s = unit(y);
      c = unit(x);
    endfunction

    function void note_frame(in_item_t it);
      longint ms, sh, ch, sp, cp, st, ct, vx, vy, vz, p, f;
      longint dxp, dyp, sc;
      out_item_t e;
      ms = move_spd;
      vx = 0; vy = 0; vz = 0;
      dxp = it.cursor_dx;
      dyp = it.cursor_dy;
      sc = it.scroll_dy;
      sincos(heading, sh, ch);
      st = rnd(ms * sh);
      ct = rnd(ms * ch);
      if (it.key_up) vy += ms;
      if (it.key_down) vy -= ms;
      if (it.key_forward) begin vz -= ct; vx -= st; end
      if (it.key_back) begin vz += ct; vx += st; end
      if (it.key_left) begin vx -= ct; vz += st; end
      if (it.key_right) begin vx += ct; vz -= st; end
      cx = clip32(cx + vx);
      cy = clip32(cy + vy);
      cz = clip32(cz + vz);
      if (it.drag) begin
        heading = heading - 32'(dxp * longint'(rot_spd));
        p = pitch + dyp * longint'(rot_spd);
        if (p > PITCH_LIM) p = PITCH_LIM;
        if (p < -PITCH_LIM) p = -PITCH_LIM;
        pitch = p;
      end
      radius = clip32(radius - sc * longint'(scroll_spd));
      if (radius < 655) radius = 655;
      sincos(heading, sh, ch);
      sincos(32'(pitch), sp, cp);
      f = rnd(sh * cp);
      e.pos_x = 32'(clip32(cx + rnd(f * radius)));
      e.pos_y = 32'(clip32(cy + rnd(sp * radius)));
      f = rnd(ch * cp);
      e.pos_z = 32'(clip32(cz + rnd(f * radius)));
      e.look_x = 32'(cx);
      e.look_y = 32'(cy);
      e.look_z = 32'(cz);
      pending.push_back(e);
    endfunction

    function void check_frame(out_item_t got);
      out_item_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (e !== got) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch %0d: exp pos %0d %0d %0d look %0d %0d %0d,",
                    " got pos %0d %0d %0d look %0d %0d %0d"},
                   checked, e.pos_x, e.pos_y, e.pos_z,
                   e.look_x, e.look_y, e.look_z,
                   got.pos_x, got.pos_y, got.pos_z,
                   got.look_x, got.look_y, got.look_z);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [23:0] cfg_data;
  in_item_t in_data;
  out_item_t out_data;

  camera_scoreboard sb;
  int idle_cycles;
  int sent;

  orbit_camera_update_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // mostly short gaps, now and then a long one, sometimes none
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // sample at the rising edge: count accepted traffic and check results
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_frame(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no progress, %0d results outstanding", sb.pending.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver stall pattern changes on the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (gap_len() + 1) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  task automatic send_frame(in_item_t it);
    @(negedge clk);
    repeat (gap_len()) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    // hold until taken at a rising edge
    do @(posedge clk); while (in_stall);
    sb.note_frame(it);
    sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(bit [1:0] idx, bit [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // registers only change with nothing in flight
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (130) @(negedge clk);
  endtask

  function automatic in_item_t rand_frame();
    in_item_t it;
    logic [63:0] raw;
    int r;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    r = $urandom_range(0, 9);
    // mostly modest cursor and scroll motion so the camera stays in range
    if (r < 7) begin
      it.cursor_dx = 16'($signed($urandom_range(0, 64)) - 32);
      it.cursor_dy = 16'($signed($urandom_range(0, 64)) - 32);
      it.scroll_dy = 16'($signed($urandom_range(0, 20)) - 10);
    end
    return it;
  endfunction

  function automatic in_item_t mk(bit [6:0] keys, int dx, int dy, int sc);
    in_item_t it;
    {it.key_up, it.key_down, it.key_forward, it.key_back,
     it.key_left, it.key_right, it.drag} = keys;
    it.cursor_dx = 16'(dx);
    it.cursor_dy = 16'(dy);
    it.scroll_dy = 16'(sc);
    return it;
  endfunction

  initial begin
    bit [23:0] ms_set[4], rs_set[4], ss_set[4];
    sb = new();
    sb.init();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MOVE_SPEED;
    cfg_data = '0;
    idle_cycles = 0;
    sent = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed frames at reset settings
    send_frame(mk(7'b0000000, 0, 0, 0));
    send_frame(mk(7'b1000000, 0, 0, 0));
    send_frame(mk(7'b0100000, 0, 0, 0));
    send_frame(mk(7'b1100000, 0, 0, 0));      // opposite keys cancel
    send_frame(mk(7'b0011000, 0, 0, 0));
    send_frame(mk(7'b0000110, 0, 0, 0));
    send_frame(mk(7'b0010000, 0, 0, 0));
    send_frame(mk(7'b0001000, 0, 0, 0));
    send_frame(mk(7'b0000100, 0, 0, 0));
    send_frame(mk(7'b0000010, 0, 0, 0));
    send_frame(mk(7'b0000001, 100, 0, 0));    // turn heading
    send_frame(mk(7'b0010000, 0, 0, 0));      // forward along new heading
    send_frame(mk(7'b0000001, 0, 32767, 0));  // pitch clamps high
    send_frame(mk(7'b0000001, 0, -32768, 0)); // pitch clamps low
    send_frame(mk(7'b0000000, 0, 32767, 0));  // no drag, no turn
    send_frame(mk(7'b0000001, -32768, 0, 0));
    send_frame(mk(7'b0000001, 32767, 0, 0));
    send_frame(mk(7'b0000000, 0, 0, 32767));  // radius to floor
    send_frame(mk(7'b0000000, 0, 0, -32768));
    send_frame(mk(7'b1011101, 5, -5, 3));
    drain();

    // settings sweep: extremes plus typical; fast scrolling drives the radius to saturation
    ms_set = '{24'hffffff, 24'd0, 24'd3277, 24'd100000};
    rs_set = '{24'hffffff, 24'd0, 24'd683565, 24'd1};
    ss_set = '{24'hffffff, 24'd0, 24'd6554, 24'd200000};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_MOVE_SPEED, ms_set[ph]);
      write_reg(CFG_ROTATE_SPEED, rs_set[ph]);
      write_reg(CFG_SCROLL_SPEED, ss_set[ph]);
      if (ph == 0) begin
        for (int k = 0; k < 40; k++) send_frame(mk(7'b1001010, 0, 0, -32768));
        for (int k = 0; k < 40; k++) send_frame(mk(7'b0110100, 0, 0, 32767));
      end
      for (int k = 0; k < N_RANDOM / 4; k++) send_frame(rand_frame());
      drain();
    end

    $display("run covered %0d frames over four register settings plus directed key,",
             sent);
    $display("drag, pitch clamp, radius floor and saturation cases; %0d errors", sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
